>>> hw/rtl/weighted_geometric_health_gate_unit_assert.svh
// Assertion macros used by the RTL core (wgh_core).
`ifndef WEIGHTED_GEOMETRIC_HEALTH_GATE_UNIT_ASSERT_SVH
`define WEIGHTED_GEOMETRIC_HEALTH_GATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define WGH_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("health gate assertion failed");

`define WGH_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("health gate assertion failed");

`else

`define WGH_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons)

`define WGH_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

>>> hw/rtl/wgh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wgh_pkg;

    localparam int LOG_FRAC = 20;
    localparam int MAG_W    = 25;
    localparam int ACC_W    = 40;

    localparam logic [16:0]      ONE_Q16    = 17'd65536;
    localparam logic [16:0]      THR_RESET  = 17'd65503;
    localparam logic [ACC_W-1:0] ACC_LIM    = 40'h80_0000_0000;

    localparam logic REG_GO_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [16:0] score;
        logic [16:0] weight;
        logic        last_item;
        logic        checks_ok;
    } in_item_t;

    typedef struct packed {
        logic [16:0] mu_value;
        logic        go;
    } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/wgh_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module wgh_mul
(
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= 64'(a) * 64'(b);
    end

    assign product = product_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wgh_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_geometric_health_gate_unit_assert.svh"

module wgh_core
    import wgh_pkg::*;
#(
    parameter int MAX_ITEMS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [16:0] go_threshold,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire in_item_t    item,
    output logic             res_valid,
    input  wire logic        res_ready,
    output out_item_t        res
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOG_MUL = 3'd1;
    localparam logic [2:0] ST_LOG_UPD = 3'd2;
    localparam logic [2:0] ST_WMUL    = 3'd3;
    localparam logic [2:0] ST_WACC    = 3'd4;
    localparam logic [2:0] ST_SEARCH  = 3'd5;
    localparam logic [2:0] ST_JUDGE   = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    localparam logic [4:0]  BIT_TOP   = 5'(LOG_FRAC - 1);
    localparam logic [17:0] HI_START  = 18'd65537;

    function automatic logic [4:0] msb_index(input logic [16:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (v[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [30:0] normalize(input logic [16:0] v, input logic [4:0] k);
        logic [30:0] ext;
        ext = {14'd0, v};
        return ext << (5'd30 - k);
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [30:0]         m_reg, m_next;
    logic [LOG_FRAC-1:0] frac_reg, frac_next;
    logic [4:0]          bit_reg, bit_next;
    logic [4:0]          k_reg, k_next;
    logic [16:0]         weight_reg, weight_next;
    logic                last_reg, last_next;
    logic                ok_reg, ok_next;
    logic                searching_reg, searching_next;
    logic [16:0]         lo_reg, lo_next;
    logic [17:0]         hi_reg, hi_next;

    logic [16:0]      score_clamped;
    logic [16:0]      weight_clamped;
    logic [MAG_W-1:0] mag;
    logic [28:0]      mag16;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      product;
    logic [31:0]      sq;
    logic [41:0]      wprod_round;
    logic [ACC_W:0]   acc_sum;
    logic [18:0]      mid_sum;
    logic [16:0]      mid;
    logic [17:0]      lo_ext;
    logic [17:0]      span;
    logic             start_log;
    logic [16:0]      log_src;
    logic [4:0]       src_k;

    assign score_clamped  = (item.score == 17'd0) ? 17'd1 :
                            ((item.score > ONE_Q16) ? ONE_Q16 : item.score);
    assign weight_clamped = (item.weight > ONE_Q16) ? ONE_Q16 : item.weight;

    assign mag   = {5'd16 - k_reg, 20'd0} - {5'd0, frac_reg};
    assign mag16 = {mag, 4'd0};

    assign mul_a = (state_reg == ST_WMUL) ? {15'd0, weight_reg} : {1'b0, m_reg};
    assign mul_b = (state_reg == ST_WMUL) ? {7'd0, mag} : {1'b0, m_reg};

    wgh_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign sq          = product[61:30];
    assign wprod_round = product[41:0] + 42'd2048;
    assign acc_sum     = {1'b0, acc_reg} + 41'(wprod_round[41:12]);
    assign lo_ext      = {1'b0, lo_reg};
    assign mid_sum     = {2'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[17:1];
    assign span        = hi_reg - lo_ext;
    assign src_k       = msb_index(log_src);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        bit_next       = bit_reg;
        k_next         = k_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        ok_next        = ok_reg;
        searching_next = searching_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        start_log      = 1'b0;
        log_src        = mid;
        item_ready     = (state_reg == ST_IDLE);
        res_valid      = (state_reg == ST_DONE);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    weight_next = weight_clamped;
                    last_next   = item.last_item;
                    ok_next     = item.checks_ok;
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        searching_next = 1'b0;
                        start_log      = 1'b1;
                        log_src        = score_clamped;
                    end
                    else if (item.last_item)
                    begin
                        searching_next = 1'b1;
                        lo_next        = '0;
                        hi_next        = HI_START;
                        state_next     = ST_SEARCH;
                    end
                end
            end
            ST_LOG_MUL:
            begin
                state_next = ST_LOG_UPD;
            end
            ST_LOG_UPD:
            begin
                if (sq[31])
                begin
                    m_next             = sq[31:1];
                    frac_next[bit_reg] = 1'b1;
                end
                else
                begin
                    m_next = sq[30:0];
                end
                if (bit_reg == 5'd0)
                begin
                    state_next = searching_reg ? ST_JUDGE : ST_WMUL;
                end
                else
                begin
                    bit_next   = bit_reg - 5'd1;
                    state_next = ST_LOG_MUL;
                end
            end
            ST_WMUL:
            begin
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                acc_next   = (acc_sum > {1'b0, ACC_LIM}) ? ACC_LIM : acc_sum[ACC_W-1:0];
                count_next = count_reg + CNT_W'(1);
                if (last_reg)
                begin
                    searching_next = 1'b1;
                    lo_next        = '0;
                    hi_next        = HI_START;
                    state_next     = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (span > 18'd1)
                begin
                    start_log = 1'b1;
                    log_src   = mid;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_JUDGE:
            begin
                if ({11'd0, mag16} >= acc_reg)
                begin
                    lo_next = mid;
                end
                else
                begin
                    hi_next = {1'b0, mid};
                end
                state_next = ST_SEARCH;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    acc_next   = '0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_log)
        begin
            k_next     = src_k;
            m_next     = normalize(log_src, src_k);
            frac_next  = '0;
            bit_next   = BIT_TOP;
            state_next = ST_LOG_MUL;
        end
    end

    assign res.mu_value = lo_reg;
    assign res.go       = (lo_reg >= go_threshold) && ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        frac_reg      <= frac_next;
        bit_reg       <= bit_next;
        k_reg         <= k_next;
        weight_reg    <= weight_next;
        last_reg      <= last_next;
        ok_reg        <= ok_next;
        searching_reg <= searching_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
    end

    `WGH_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `WGH_ASSERT_IMP(a_acc_bound, clk, rst_n, 1'b1, acc_reg <= ACC_LIM)
    `WGH_ASSERT_IMP(a_search_order, clk, rst_n, state_reg == ST_SEARCH, hi_reg > lo_ext)
    `WGH_ASSERT_IMP(a_mu_range, clk, rst_n, res_valid, lo_reg <= ONE_Q16)
    `WGH_ASSERT_NXT(a_clear_after_result, clk, rst_n, res_valid && res_ready,
                    acc_reg == '0 && count_reg == '0)

endmodule

`default_nettype wire

>>> hw/rtl/weighted_geometric_health_gate_unit.sv
// Weighted geometric health gate.
// Input channel (item_valid/item_ready/item): one subsystem score and weight
// per item, Q1.16; last_item closes an evaluation and samples checks_ok.
// Output channel (result_valid/result_ready/result): one item per evaluation,
// mu_value (Q1.16) and go = mu_value >= go_threshold and checks_ok.
// APB port: register 0 at byte address 0 holds go_threshold (reset 65503).
// Each counted item goes through a normalize step, 20 squaring steps on the
// shared 32x32 multiplier (a multiply state and an update state each), then
// one weight multiply and one accumulate step. A last item adds the exp
// search: up to 17 bisection steps, each a full log on the same multiplier
// and a judge state, before the result is registered. Items past MAX_ITEMS
// are not counted; a last one starts the search. item_ready is low while an
// item is in work. Reset clears the accumulator, item count and output valid
// flag and loads the default threshold. A stalled receiver holds the result
// in the output register; the block takes the next item meanwhile and waits
// only if a further result is ready before the held one is taken.
`timescale 1ns / 1ps
`default_nettype none

module weighted_geometric_health_gate_unit
    import wgh_pkg::*;
#(
    parameter int MAX_ITEMS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire in_item_t    item,
    output logic             result_valid,
    input  wire logic        result_ready,
    output out_item_t        result
);

    logic [16:0] thr_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        core_res_valid;
    logic        core_res_ready;
    out_item_t   core_res;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_GO_THRESHOLD);
    assign prdata    = (paddr[2] == REG_GO_THRESHOLD) ? {15'd0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            thr_reg <= pwdata[16:0];
        end
    end

    wgh_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .go_threshold (thr_reg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .res_valid    (core_res_valid),
        .res_ready    (core_res_ready),
        .res          (core_res)
    );

    assign core_res_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res_ready)
        begin
            out_valid_reg <= core_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_valid && core_res_ready)
        begin
            out_item_reg <= core_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

>>> tb/sv/weighted_geometric_health_gate_unit_tb.sv
`timescale 1ns / 1ps

module weighted_geometric_health_gate_unit_tb;
    import wgh_pkg::*;

    localparam int         MAX_SCORES        = 16;
    localparam int         IDLE_PCT          = 16;
    localparam int         SETTLE_CYCLES     = 60;
    localparam int         STALL_LIMIT       = 20000;
    localparam int         PHASE_ITEMS       = 280;
    localparam longint     LOG_SUM_FLOOR     = -(longint'(1) << 39);
    localparam logic [2:0] GO_THRESHOLD_ADDR = {REG_GO_THRESHOLD, 2'b00};
    localparam logic [2:0] SPARE_ADDR        = 3'd4;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    in_item_t    item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_item_t   result;

    logic [16:0] go_threshold_q16 = THR_RESET;
    longint      log_sum          = 0;
    int          scores_taken     = 0;
    out_item_t   expected_gates[$];
    int          error_count      = 0;
    int          idle_pct         = IDLE_PCT;
    int          quiet_cycles     = 0;

    always #6 clk = ~clk;

    weighted_geometric_health_gate_unit #(
        .MAX_ITEMS(MAX_SCORES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    function automatic longint score_log2_q20(input logic [16:0] s);
        int          k;
        int          i;
        logic [63:0] m;
        longint      frac;
        k = 0;
        frac = 0;
        while (k < 16 && (s >> (k + 1)) != 0)
        begin
            k++;
        end
        m = 64'(s) << (30 - k);
        for (i = 0; i < LOG_FRAC; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | (longint'(1) << (LOG_FRAC - 1 - i));
            end
        end
        return longint'(k - 16) * (longint'(1) << LOG_FRAC) + frac;
    endfunction

    function automatic logic [16:0] mu_from_log_sum(input longint acc);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = 65537;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (score_log2_q20(17'(mid)) * 16 <= acc)
                lo = mid;
            else
                hi = mid;
        end
        return 17'(lo);
    endfunction

    function automatic void absorb_score(input in_item_t it);
        logic [16:0]     s;
        logic [16:0]     w;
        longint unsigned mag;
        longint unsigned prod;
        out_item_t       gate;
        s = it.score;
        w = it.weight;
        if (s == 0)
            s = 17'd1;
        if (s > ONE_Q16)
            s = ONE_Q16;
        if (w > ONE_Q16)
            w = ONE_Q16;
        if (scores_taken < MAX_SCORES)
        begin
            mag = longint'(-score_log2_q20(s));
            prod = (64'(w) * mag + 64'd2048) >> 12;
            log_sum = log_sum - longint'(prod);
            if (log_sum < LOG_SUM_FLOOR)
                log_sum = LOG_SUM_FLOOR;
            scores_taken++;
        end
        if (it.last_item)
        begin
            gate.mu_value = mu_from_log_sum(log_sum);
            gate.go = (gate.mu_value >= go_threshold_q16) && it.checks_ok;
            expected_gates.push_back(gate);
            log_sum = 0;
            scores_taken = 0;
        end
    endfunction

    function automatic in_item_t pack_item(input logic [16:0] s, input logic [16:0] w,
                                           input logic last, input logic ok);
        in_item_t it;
        it.score = s;
        it.weight = w;
        it.last_item = last;
        it.checks_ok = ok;
        return it;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                absorb_score(item);
            if (result_valid && result_ready)
            begin
                if (expected_gates.size() == 0)
                begin
                    $display("%0t: result with none expected: mu_value %0d go %0b",
                             $time, result.mu_value, result.go);
                    error_count++;
                end
                else
                begin
                    want = expected_gates.pop_front();
                    if (result.mu_value !== want.mu_value)
                    begin
                        $display("%0t: mu_value expected %0d actual %0d",
                                 $time, want.mu_value, result.mu_value);
                        error_count++;
                    end
                    if (result.go !== want.go)
                    begin
                        $display("%0t: go expected %0b actual %0b",
                                 $time, want.go, result.go);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("weighted_geometric_health_gate_unit_tb: errors");
                $finish;
            end
        end
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic wait_idle;
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_gates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == GO_THRESHOLD_ADDR)
            go_threshold_q16 = data[16:0];
        @(posedge clk);
    endtask

    task automatic set_threshold(input logic [16:0] thr);
        wait_idle();
        write_reg(GO_THRESHOLD_ADDR, {15'($urandom), thr});
    endtask

    task automatic send_evaluation(input int len);
        int          k;
        int          share;
        logic [16:0] s;
        logic [16:0] w;
        share = 65536 / len;
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: s = 17'(65536 - int'($urandom_range(0, 300)));
                5, 6:          s = 17'($urandom);
                7:             s = 17'($urandom_range(0, 1));
                8:             s = 17'($urandom_range(65537, 131071));
                default:       s = 17'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: w = 17'(share + int'($urandom_range(0, 64)) - 32);
                6, 7:             w = 17'($urandom_range(0, 65536));
                8:                w = 17'($urandom_range(65536, 131071));
                default:          w = 17'($urandom_range(0, 15));
            endcase
            send_item(pack_item(s, w, k == len - 1, $urandom_range(0, 99) < 85));
        end
    endtask

    task automatic test_clamp_extremes;
        send_item(pack_item(17'd65536, 17'd65536, 1'b1, 1'b1));
        send_item(pack_item(17'd0, 17'd65536, 1'b1, 1'b1));
        send_item(pack_item(17'd131071, 17'd131071, 1'b1, 1'b0));
        send_item(pack_item(17'd1, 17'd0, 1'b1, 1'b1));
        send_item(pack_item(17'h15555, 17'h0AAAA, 1'b1, 1'b1));
        send_item(pack_item(17'd65503, 17'd65536, 1'b1, 1'b1));
        send_item(pack_item(17'd65502, 17'd65536, 1'b1, 1'b1));
        send_item(pack_item(17'd16384, 17'd32768, 1'b0, 1'b0));
        send_item(pack_item(17'd65536, 17'd32768, 1'b1, 1'b1));
        send_item(pack_item(17'd1, 17'd65536, 1'b0, 1'b1));
        send_item(pack_item(17'd1, 17'd65536, 1'b1, 1'b1));
    endtask

    task automatic test_item_overflow;
        int k;
        for (k = 0; k < MAX_SCORES; k++)
            send_item(pack_item(17'd32768, 17'd4096, 1'b0, 1'b1));
        send_item(pack_item(17'd1, 17'd65536, 1'b1, 1'b1));
    endtask

    task automatic test_threshold_register;
        set_threshold(ONE_Q16);
        write_reg(SPARE_ADDR, 32'd0);
        send_item(pack_item(17'd65535, 17'd65536, 1'b1, 1'b1));
        send_item(pack_item(17'd65536, 17'd65536, 1'b1, 1'b1));
        set_threshold(17'h1FFFF);
        send_item(pack_item(17'd65536, 17'd65536, 1'b1, 1'b1));
        set_threshold(17'd0);
        send_item(pack_item(17'd1, 17'd65536, 1'b0, 1'b1));
        send_item(pack_item(17'd1, 17'd65536, 1'b1, 1'b1));
        set_threshold(17'd65535);
        send_item(pack_item(17'd65535, 17'd65536, 1'b1, 1'b1));
    endtask

    task automatic test_random_evaluations(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(MAX_SCORES + 1, MAX_SCORES + 8);
                1:       len = 0;
                default: len = $urandom_range(1, MAX_SCORES);
            endcase
            if (len == 0)
            begin
                send_item(pack_item(17'($urandom), 17'($urandom), 1'b1, 1'($urandom)));
                sent++;
            end
            else
            begin
                send_evaluation(len);
                sent += len;
            end
        end
    endtask

    task automatic test_threshold_sweep;
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_threshold(THR_RESET);
                1:       set_threshold(17'($urandom_range(65000, 65536)));
                2:       set_threshold(ONE_Q16);
                3:       set_threshold(17'd0);
                4:       set_threshold(17'($urandom_range(0, 65536)));
                default: set_threshold(17'($urandom_range(65400, 65535)));
            endcase
            idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            test_random_evaluations(PHASE_ITEMS);
        end
        idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_clamp_extremes();
        test_item_overflow();
        test_threshold_register();
        test_threshold_sweep();
        wait_idle();
        if (error_count == 0)
            $display("weighted_geometric_health_gate_unit_tb: clean");
        else
            $display("weighted_geometric_health_gate_unit_tb: errors");
        $finish;
    end

endmodule
